FILE: rtl/core/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index 2*pos+2 needs one bit more than the count
    localparam int IDX_W    = CNT_W + 1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    localparam key_t EMPTY_KEY = -32'sd1;

    // decision of the shared compare unit
    typedef struct packed {
        logic take_l;
        logic take_r;
    } cmp_res_t;

endpackage

FILE: rtl/core/min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps

// Binary min-heap of signed 32-bit keys, up to CAPACITY entries.
// Input channel s_*: s_cmd selects push of s_key_in or pop of the minimum.
// Result channel m_*: one word per input word, giving the heap after the
// operation: minimum key (-1 when empty), empty flag, entry count, status
// (ok, pop on empty ignored, push on full ignored).
// One input word is processed at a time; s_ready is high only while the
// sequencer is idle. Each heap level takes a registered read of the key RAM
// (parent, or both children) and then one compare/write step through the
// shared compare unit; ignored operations skip the sift.
// A finished result sits in the output register; the next word is accepted
// while it waits. If the receiver stalls, the following result holds in the
// sequencer until the output register frees, so no word is lost.
// aresetn (synchronous, active low) empties the heap; the key RAM is not
// cleared since only entries below the count are ever used.
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  key_t             s_key_in,
    output logic             m_valid,
    input  logic             m_ready,
    output key_t             m_min_key,
    output logic             m_is_empty,
    output logic [CNT_W-1:0] m_entry_count,
    output logic [1:0]       m_status
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_RD   = 3'd1;
    localparam logic [2:0] ST_UP_CMP  = 3'd2;
    localparam logic [2:0] ST_DN_LOAD = 3'd3;
    localparam logic [2:0] ST_DN_RD   = 3'd4;
    localparam logic [2:0] ST_DN_CMP  = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    logic [2:0] state_reg, state_next;
    addr_t      pos_reg, pos_next;
    cnt_t       count_reg, count_next;
    key_t       cur_key_reg, cur_key_next;
    logic [1:0] status_reg, status_next;
    key_t       root_reg;

    logic       m_valid_reg;
    key_t       m_min_key_reg;
    logic       m_is_empty_reg;
    cnt_t       m_entry_count_reg;
    logic [1:0] m_status_reg;

    logic     wr_en;
    addr_t    wr_addr;
    key_t     wr_data;
    addr_t    rd_addr_a, rd_addr_b;
    key_t     rd_data_a, rd_data_b;
    cmp_res_t cmp_res;
    logic     cmp_up;
    key_t     cmp_cur_key, cmp_l_key;

    addr_t parent;
    idx_t  left_idx, right_idx, n_idx;
    logic  left_in, right_in;
    logic  accept, out_free, full;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign s_ready  = (state_reg == ST_IDLE);

    assign parent    = (pos_reg - addr_t'(1)) >> 1;
    assign left_idx  = IDX_W'({pos_reg, 1'b1});
    assign right_idx = left_idx + idx_t'(1);
    assign n_idx     = IDX_W'(count_reg);
    assign left_in   = (left_idx < n_idx);
    assign right_in  = (right_idx < n_idx);

    // sifting up asks whether the moving key is below its parent
    assign cmp_up      = (state_reg == ST_UP_CMP);
    assign cmp_cur_key = cmp_up ? rd_data_a : cur_key_reg;
    assign cmp_l_key   = cmp_up ? cur_key_reg : rd_data_a;

    mhpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_data_a(rd_data_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_b(rd_data_b)
    );

    mhpq_cmp u_cmp (
        .cur_key(cmp_cur_key),
        .l_key  (cmp_l_key),
        .l_ok   (1'b1),
        .r_key  (rd_data_b),
        .r_ok   ((state_reg == ST_DN_CMP) && right_in),
        .res    (cmp_res)
    );

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        cur_key_next = cur_key_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = cur_key_reg;
        rd_addr_a    = left_idx[ADDR_W-1:0];
        rd_addr_b    = right_idx[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                // last entry of the heap, read ahead for a pop
                rd_addr_a = addr_t'(count_reg - cnt_t'(1));
                if (accept) begin
                    status_next = STATUS_OK;
                    if (s_cmd == CMD_PUSH) begin
                        if (full) begin
                            status_next = STATUS_PUSH_FULL;
                            state_next  = ST_FIN;
                        end else begin
                            cur_key_next = s_key_in;
                            pos_next     = addr_t'(count_reg);
                            count_next   = count_reg + cnt_t'(1);
                            state_next   = ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STATUS_POP_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            count_next = count_reg - cnt_t'(1);
                            state_next = (count_reg == cnt_t'(1)) ? ST_FIN : ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                rd_addr_a = parent;
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (cmp_res.take_l) begin
                    // parent moves down into the hole
                    wr_data    = rd_data_a;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_LOAD: begin
                cur_key_next = rd_data_a;
                pos_next     = '0;
                state_next   = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (left_in) begin
                    state_next = ST_DN_CMP;
                end else begin
                    wr_en      = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DN_CMP: begin
                wr_en = 1'b1;
                priority if (cmp_res.take_r) begin
                    wr_data    = rd_data_b;
                    pos_next   = right_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end else if (cmp_res.take_l) begin
                    wr_data    = rd_data_a;
                    pos_next   = left_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        cur_key_reg <= cur_key_next;
        status_reg  <= status_next;
        // shadow of entry 0 for the minimum
        if (wr_en && (wr_addr == '0)) begin
            root_reg <= wr_data;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_min_key_reg     <= (count_reg == '0) ? EMPTY_KEY : root_reg;
            m_is_empty_reg    <= (count_reg == '0);
            m_entry_count_reg <= count_reg;
            m_status_reg      <= status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_min_key     = m_min_key_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_status      = m_status_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == CMD_PUSH) && !full |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("push did not grow the heap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == CMD_POP) && (count_reg != '0)
        |=> count_reg == $past(count_reg) - cnt_t'(1))
        else $error("pop did not shrink the heap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg != ST_IDLE) && (state_reg != ST_FIN))
        else $error("key RAM written outside a sift");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != STATUS_OK) |-> $stable(count_reg) || !s_ready)
        else $error("ignored operation changed the count");

endmodule

FILE: rtl/core/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: rtl/core/mhpq_cmp.sv
`timescale 1ns / 1ps

module mhpq_cmp
    import mhpq_pkg::*;
(
    input  key_t     cur_key,
    input  key_t     l_key,
    input  logic     l_ok,
    input  key_t     r_key,
    input  logic     r_ok,
    output cmp_res_t res
);

    key_t best_key;

    // strict compares: ties keep the current key, then the left child
    always_comb begin
        res.take_l = l_ok && (l_key < cur_key);
        best_key   = res.take_l ? l_key : cur_key;
        res.take_r = r_ok && (r_key < best_key);
    end

endmodule
